[rtl/first_fit_heap_allocator_assert.svh]
// Assertion macros shared by the allocator modules.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");

`endif

[rtl/ffha_pkg.sv]
package ffha_pkg;

	localparam int MAX_ENT = 64;
	localparam int HDR_DEPTH = 2048;
	localparam int HDR_IDX_W = 11;
	localparam logic [14:0] HEAP_MAX = 15'd16384;
	localparam logic [14:0] HEAP_MIN = 15'd64;
	localparam logic [14:0] HDR_BYTES = 15'd24;
	localparam logic [14:0] ALIGN_MASK = 15'd15;
	localparam logic [15:0] SPLIT_MIN = 16'd40;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_RESIZE = 2'd2;
	localparam logic [1:0] KIND_STATS = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NULL = 3'd1;
	localparam logic [2:0] ST_OOM = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam logic CFG_HEAP_BASE = 1'b0;
	localparam logic CFG_HEAP_LEN = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] pointer;
		logic [31:0] request_size;
	} cmd_t;

	typedef struct packed {
		logic [31:0] result_address;
		logic [2:0] status;
		logic [14:0] total_bytes;
		logic [14:0] used_bytes;
		logic [14:0] avail_bytes;
	} rsp_t;

	typedef struct packed {
		logic vld;
		logic [14:0] off;
		logic [14:0] size;
	} ent_t;

	typedef enum logic [2:0] {
		FL_HOLD,
		FL_INIT,
		FL_REPLACE,
		FL_REMOVE,
		FL_PUSH,
		FL_ROTATE
	} fl_op_t;

	typedef struct packed {
		fl_op_t op;
		logic [14:0] a;
		ent_t ent;
	} fl_ctrl_t;

	typedef enum logic [3:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_DECODE,
		FSM_LOOKUP,
		FSM_MATCH,
		FSM_SELECT,
		FSM_APPLY,
		FSM_HDR,
		FSM_PUSH,
		FSM_STATS,
		FSM_DONE
	} fsm_t;

endpackage

[rtl/ffha_cell.sv]
module ffha_cell import ffha_pkg::*; (
	input logic clk,
	input logic arst_n,
	input fl_ctrl_t ctrl,
	input logic sel,
	input logic after,
	input ent_t left,
	input ent_t right,
	output ent_t cur,
	output logic hit
);

	logic vld_q;
	logic [14:0] off_q;
	logic [14:0] size_q;
	logic hit_q;
	ent_t nxt;

	assign cur = '{vld: vld_q, off: off_q, size: size_q};
	assign hit = hit_q;

	always_comb begin
		nxt = cur;
		unique case (ctrl.op)
			FL_HOLD: nxt = cur;
			FL_INIT: begin
				if (sel) begin
					nxt = left;
				end else begin
					nxt.vld = 1'b0;
				end
			end
			FL_REPLACE: nxt = sel ? ctrl.ent : cur;
			FL_REMOVE: nxt = after ? right : cur;
			FL_PUSH: nxt = left;
			FL_ROTATE: nxt = left;
			default: nxt = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			vld_q <= nxt.vld;
			hit_q <= vld_q && (size_q >= ctrl.a);
		end
	end

	always_ff @(posedge clk) begin
		off_q <= nxt.off;
		size_q <= nxt.size;
	end

endmodule

[rtl/ffha_free_list.sv]
module ffha_free_list import ffha_pkg::*; (
	input logic clk,
	input logic arst_n,
	input fl_ctrl_t ctrl,
	input logic [MAX_ENT-1:0] sel,
	input logic [MAX_ENT-1:0] after,
	output logic [MAX_ENT-1:0] first,
	output logic [MAX_ENT-1:0] first_after,
	output logic any,
	output ent_t sel_ent,
	output ent_t head,
	output logic full
);

	ent_t cells [MAX_ENT];
	ent_t lefts [MAX_ENT];
	ent_t rights [MAX_ENT];
	logic [MAX_ENT-1:0] hits;

	for (genvar j = 0; j < MAX_ENT; j++) begin : g_cell
		if (j == 0) begin : g_head
			assign lefts[j] = (ctrl.op == FL_ROTATE) ? cells[MAX_ENT-1] : ctrl.ent;
		end else begin : g_body
			assign lefts[j] = cells[j-1];
		end
		if (j == MAX_ENT - 1) begin : g_tail
			assign rights[j] = '0;
		end else begin : g_inner
			assign rights[j] = cells[j+1];
		end
		ffha_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.sel(sel[j]),
			.after(after[j]),
			.left(lefts[j]),
			.right(rights[j]),
			.cur(cells[j]),
			.hit(hits[j])
		);
	end

	assign first = hits & (~hits + {{(MAX_ENT-1){1'b0}}, 1'b1});
	assign first_after = ~(first - {{(MAX_ENT-1){1'b0}}, 1'b1});
	assign any = |hits;
	assign head = cells[0];
	assign full = cells[MAX_ENT-1].vld;

	always_comb begin
		sel_ent = '0;
		for (int j = 0; j < MAX_ENT; j++) begin
			if (first[j]) begin
				sel_ent = sel_ent | cells[j];
			end
		end
	end

endmodule

[rtl/first_fit_heap_allocator.sv]
// First-fit heap allocator with a free list held in a row of 64 cells.
// A command transaction (cmd, cmd_valid, cmd_stall) carries kind, pointer
// and request_size; each command gives exactly one response transaction
// (rsp, rsp_valid, rsp_stall), in order. Commands are taken one at a time:
// cmd_stall is low only while the block waits for a new command.
// Null, oversized and badly placed requests are answered from decode. A
// release or resize first reads the block header; a release then pushes
// the block onto the free list, an allocate or a moving resize matches the
// cells and updates the free list and headers. A statistics query rotates
// the whole cell row once past the adder; a search that finds no block
// answers from the select step. The next command is taken at the earliest
// in the cycle after its predecessor's response is loaded. Allocation
// matches every cell in parallel; the header store is a registered-read
// memory. The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) is always ready. Writing the heap length, and reset, start a
// pass that clears the header store and rebuilds the free list; no command
// is taken until it ends. While the receiver holds rsp_stall, the
// finished response stays in the output register and the next command
// is still taken and worked on, then waits until the register is free.
module first_fit_heap_allocator import ffha_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input cmd_t cmd,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data
);

	`include "first_fit_heap_allocator_assert.svh"

	fsm_t st_q, st_d;
	cmd_t cmd_q;
	logic [31:0] heap_base_q;
	logic [14:0] heap_len_q;
	logic [14:0] a_q;
	logic [14:0] off_q;
	logic [14:0] hsize_q;
	logic [14:0] alloc_off_q;
	logic [14:0] bsz_q;
	logic rel_q;
	logic resize_q;
	ent_t sel_ent_q;
	logic [MAX_ENT-1:0] first_q;
	logic [MAX_ENT-1:0] after_q;
	logic [31:0] newaddr_q;
	rsp_t pend_q;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic [HDR_IDX_W-1:0] clr_q;
	logic [5:0] cnt_q;
	logic [15:0] acc_q;
	logic [15:0] hdr_mem [HDR_DEPTH];
	logic [15:0] rd_q;

	fl_ctrl_t fl_ctrl;
	logic [MAX_ENT-1:0] fl_sel;
	logic [MAX_ENT-1:0] fl_first;
	logic [MAX_ENT-1:0] fl_after;
	logic fl_any;
	ent_t fl_sel_ent;
	ent_t fl_head;
	logic fl_full;

	logic mem_we;
	logic [HDR_IDX_W-1:0] mem_wa;
	logic [15:0] mem_wd;
	logic [HDR_IDX_W-1:0] mem_ra;

	logic [31:0] ptr_off;
	logic off_ok;
	logic req_zero;
	logic req_le;
	logic ptr_null;
	logic [14:0] a_calc;
	logic split;
	logic [14:0] roff;
	logic [14:0] rsz;
	logic [15:0] acc_d;
	logic size_wr;
	logic [14:0] size_clamp;
	logic rsp_load;

	ffha_free_list u_free_list (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(fl_ctrl),
		.sel(fl_sel),
		.after(after_q),
		.first(fl_first),
		.first_after(fl_after),
		.any(fl_any),
		.sel_ent(fl_sel_ent),
		.head(fl_head),
		.full(fl_full)
	);

	assign cfg_ready = 1'b1;
	assign cmd_stall = (st_q != FSM_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign size_wr = cfg_valid && (cfg_index == CFG_HEAP_LEN);

	always_comb begin
		size_clamp = cfg_data[14:0];
		if (size_clamp < HEAP_MIN) begin
			size_clamp = HEAP_MIN;
		end else if (size_clamp > HEAP_MAX) begin
			size_clamp = HEAP_MAX;
		end
	end

	assign ptr_off = cmd_q.pointer - heap_base_q - {17'd0, HDR_BYTES};
	assign off_ok = (ptr_off < {17'd0, heap_len_q}) && (ptr_off[2:0] == 3'd0);
	assign req_zero = (cmd_q.request_size == 32'd0);
	assign req_le = (cmd_q.request_size <= {17'd0, heap_len_q});
	assign ptr_null = (cmd_q.pointer == 32'd0);
	assign a_calc = (cmd_q.request_size[14:0] + ALIGN_MASK) & ~ALIGN_MASK;
	assign split = ({1'b0, sel_ent_q.size} >= ({1'b0, a_q} + SPLIT_MIN));
	assign roff = sel_ent_q.off + HDR_BYTES + a_q;
	assign rsz = sel_ent_q.size - a_q - HDR_BYTES;
	assign acc_d = acc_q + (fl_head.vld ? ({1'b0, fl_head.size} + {1'b0, HDR_BYTES}) : 16'd0);
	assign rsp_load = (st_q == FSM_DONE) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		st_d = st_q;
		fl_ctrl = '{op: FL_HOLD, a: a_q, ent: '0};
		fl_sel = '0;
		mem_we = 1'b0;
		mem_wa = off_q[13:3];
		mem_wd = '0;
		mem_ra = ptr_off[13:3];
		unique case (st_q)
			FSM_CLEAR: begin
				fl_ctrl.op = FL_INIT;
				fl_ctrl.ent = '{vld: 1'b1, off: 15'd0, size: heap_len_q - HDR_BYTES};
				fl_sel = {{(MAX_ENT-1){1'b0}}, 1'b1};
				mem_we = 1'b1;
				mem_wa = clr_q;
				if (clr_q == {HDR_IDX_W{1'b1}}) begin
					st_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (cmd_valid) begin
					st_d = FSM_DECODE;
				end
			end
			FSM_DECODE: begin
				unique case (cmd_q.kind)
					KIND_STATS: st_d = FSM_STATS;
					KIND_ALLOC: st_d = (req_zero || !req_le) ? FSM_DONE : FSM_MATCH;
					KIND_RESIZE: begin
						if (ptr_null) begin
							st_d = (req_zero || !req_le) ? FSM_DONE : FSM_MATCH;
						end else begin
							st_d = off_ok ? FSM_LOOKUP : FSM_DONE;
						end
					end
					default: st_d = (!ptr_null && off_ok) ? FSM_LOOKUP : FSM_DONE;
				endcase
			end
			FSM_LOOKUP: begin
				if (!rd_q[15]) begin
					st_d = FSM_DONE;
				end else if (rel_q) begin
					st_d = fl_full ? FSM_DONE : FSM_PUSH;
				end else if (req_le && (a_q <= rd_q[14:0])) begin
					st_d = FSM_DONE;
				end else begin
					st_d = req_le ? FSM_MATCH : FSM_DONE;
				end
			end
			FSM_MATCH: st_d = FSM_SELECT;
			FSM_SELECT: st_d = fl_any ? FSM_APPLY : FSM_DONE;
			FSM_APPLY: begin
				mem_wa = roff[13:3];
				mem_wd = {1'b0, rsz};
				if (split) begin
					fl_ctrl.op = FL_REPLACE;
					fl_ctrl.ent = '{vld: 1'b1, off: roff, size: rsz};
					fl_sel = first_q;
					mem_we = 1'b1;
				end else begin
					fl_ctrl.op = FL_REMOVE;
				end
				st_d = FSM_HDR;
			end
			FSM_HDR: begin
				mem_we = 1'b1;
				mem_wa = alloc_off_q[13:3];
				mem_wd = {1'b1, bsz_q};
				st_d = (resize_q && !fl_full) ? FSM_PUSH : FSM_DONE;
			end
			FSM_PUSH: begin
				fl_ctrl.op = FL_PUSH;
				fl_ctrl.ent = '{vld: 1'b1, off: off_q, size: hsize_q};
				mem_we = 1'b1;
				mem_wd = {1'b0, hsize_q};
				st_d = FSM_DONE;
			end
			FSM_STATS: begin
				fl_ctrl.op = FL_ROTATE;
				if (cnt_q == 6'd63) begin
					st_d = FSM_DONE;
				end
			end
			FSM_DONE: begin
				if (rsp_load) begin
					st_d = FSM_IDLE;
				end
			end
			default: st_d = FSM_CLEAR;
		endcase
		if (size_wr) begin
			st_d = FSM_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FSM_CLEAR;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
			heap_base_q <= 32'd0;
			heap_len_q <= HEAP_MAX;
		end else begin
			st_q <= st_d;
			if (size_wr) begin
				clr_q <= '0;
			end else if (st_q == FSM_CLEAR) begin
				clr_q <= clr_q + {{(HDR_IDX_W-1){1'b0}}, 1'b1};
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid && (cfg_index == CFG_HEAP_BASE)) begin
				heap_base_q <= cfg_data;
			end
			if (size_wr) begin
				heap_len_q <= size_clamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hdr_mem[mem_wa] <= mem_wd;
		end
		rd_q <= hdr_mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= pend_q;
		end
		unique case (st_q)
			FSM_IDLE: cmd_q <= cmd;
			FSM_DECODE: begin
				pend_q.result_address <= '0;
				pend_q.total_bytes <= '0;
				pend_q.used_bytes <= '0;
				pend_q.avail_bytes <= '0;
				a_q <= a_calc;
				off_q <= ptr_off[14:0];
				acc_q <= 16'd0;
				cnt_q <= 6'd0;
				resize_q <= 1'b0;
				rel_q <= (cmd_q.kind == KIND_RELEASE) || req_zero;
				if (cmd_q.kind == KIND_ALLOC || (cmd_q.kind == KIND_RESIZE && ptr_null)) begin
					if (req_zero) begin
						pend_q.status <= ST_NULL;
					end else if (!req_le) begin
						pend_q.status <= ST_OOM;
					end else begin
						pend_q.status <= ST_OK;
					end
				end else if (cmd_q.kind == KIND_RELEASE && ptr_null) begin
					pend_q.status <= ST_NULL;
				end else if (cmd_q.kind != KIND_STATS && !off_ok) begin
					pend_q.status <= ST_INVALID;
				end else begin
					pend_q.status <= ST_OK;
				end
			end
			FSM_LOOKUP: begin
				hsize_q <= rd_q[14:0];
				resize_q <= !rel_q;
				if (!rd_q[15]) begin
					pend_q.status <= ST_INVALID;
				end else if (rel_q) begin
					if (fl_full) begin
						pend_q.status <= ST_FULL;
					end
				end else if (req_le && (a_q <= rd_q[14:0])) begin
					pend_q.result_address <= cmd_q.pointer;
				end else if (!req_le) begin
					pend_q.status <= ST_OOM;
				end
			end
			FSM_SELECT: begin
				sel_ent_q <= fl_sel_ent;
				first_q <= fl_first;
				after_q <= fl_after;
				if (!fl_any) begin
					pend_q.status <= ST_OOM;
				end
			end
			FSM_APPLY: begin
				alloc_off_q <= sel_ent_q.off;
				bsz_q <= split ? a_q : sel_ent_q.size;
				newaddr_q <= heap_base_q + {17'd0, sel_ent_q.off} + {17'd0, HDR_BYTES};
			end
			FSM_HDR: begin
				pend_q.result_address <= newaddr_q;
				if (resize_q && fl_full) begin
					pend_q.status <= ST_FULL;
				end
			end
			FSM_STATS: begin
				acc_q <= acc_d;
				cnt_q <= cnt_q + 6'd1;
				pend_q.total_bytes <= heap_len_q;
				pend_q.avail_bytes <= acc_d[14:0];
				pend_q.used_bytes <= heap_len_q - acc_d[14:0];
			end
			default: begin
			end
		endcase
	end

	`FFHA_ASSERT_IMP(a_clear_stalls, st_q == FSM_CLEAR, cmd_stall)
	`FFHA_ASSERT_IMP(a_apply_onehot, st_q == FSM_APPLY, $onehot(first_q))
	`FFHA_ASSERT_IMP(a_push_room, st_q == FSM_PUSH, !fl_full)
	`FFHA_ASSERT_NXT(a_done_to_idle, rsp_load && !size_wr, st_q == FSM_IDLE && rsp_valid_q)

endmodule
